/* src/gdoy_pkg.sv */
// ----------------------------------------------------------------------------
// gdoy_pkg: shared definitions for the Gregorian day-of-year converter
// Field widths, mode codes, the result bundle and the calendar lookups.
// ----------------------------------------------------------------------------
package gdoy_pkg;

    localparam int YEAR_W  = 16;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int DOY_W   = 9;

    localparam logic MODE_DATE    = 1'b0;  // year/month/day -> day of year
    localparam logic MODE_ORDINAL = 1'b1;  // year/day of year -> month/day

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam int                 NUM_MONTHS = 12;

    localparam logic [DOY_W-1:0] YEAR_LEN      = 9'd365;
    localparam logic [DOY_W-1:0] LEAP_YEAR_LEN = 9'd366;

    // Divisibility by 25 through the modular inverse of 25 mod 2^16:
    // y is a multiple of 25 exactly when (y * inverse) mod 2^16 <= 65535 / 25.
    localparam logic [YEAR_W-1:0] DIV25_INV   = 16'h5C29;
    localparam logic [YEAR_W-1:0] DIV25_LIMIT = 16'((2 ** YEAR_W - 1) / 25);

    typedef struct packed {
        logic               valid_res;
        logic               leap;
        logic [DAY_W-1:0]   days_in_month;
        logic [DOY_W-1:0]   ordinal_day;
        logic [MONTH_W-1:0] month_out;
        logic [DAY_W-1:0]   day_out;
    } gdoy_res_t;

    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [YEAR_W-1:0] prod;
        logic              div4;
        logic              div16;
        logic              div25;
        prod  = y * DIV25_INV;
        div4  = (y[1:0] == 2'd0);
        div16 = (y[3:0] == 4'd0);
        div25 = (prod <= DIV25_LIMIT);
        // divisible by 400, or by 4 and not by 100
        return (div16 && div25) || (div4 && !div25);
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic lp);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            MONTH_FEB:                                  len = lp ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Days in the year before the first of month m.
    function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m,
                                                     input logic lp);
        logic [DOY_W-1:0] base;
        logic             adj;
        case (m)
            4'd1:    base = 9'd0;
            4'd2:    base = 9'd31;
            4'd3:    base = 9'd59;
            4'd4:    base = 9'd90;
            4'd5:    base = 9'd120;
            4'd6:    base = 9'd151;
            4'd7:    base = 9'd181;
            4'd8:    base = 9'd212;
            4'd9:    base = 9'd243;
            4'd10:   base = 9'd273;
            4'd11:   base = 9'd304;
            4'd12:   base = 9'd334;
            default: base = 9'd0;
        endcase
        adj = lp && (m > MONTH_FEB) && (m <= MONTH_DEC);
        return base + {{(DOY_W-1){1'b0}}, adj};
    endfunction

endpackage

/* src/gregorian_date_day_of_year.sv */
// ----------------------------------------------------------------------------
// gregorian_date_day_of_year: Gregorian date / day-of-year converter
// Timing: a request passes through the input register, then the result register;
// done rises at the same edge that loads the result register.
// Throughput: one transaction per cycle; busy is never raised.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset clears the stage valid flags; no result is issued out of reset.
// ----------------------------------------------------------------------------
module gregorian_date_day_of_year
    import gdoy_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               mode,
    input  logic [YEAR_W-1:0]  year,
    input  logic [MONTH_W-1:0] month,
    input  logic [DAY_W-1:0]   day,
    input  logic [DOY_W-1:0]   day_of_year,
    output logic               done,
    output logic               valid_res,
    output logic               leap,
    output logic [DAY_W-1:0]   days_in_month,
    output logic [DOY_W-1:0]   ordinal_day,
    output logic [MONTH_W-1:0] month_out,
    output logic [DAY_W-1:0]   day_out
);

    // Input stage: capture the request on every accepted transaction.
    logic               accept;
    logic               in_vld_reg;
    logic               mode_reg;
    logic [YEAR_W-1:0]  year_reg;
    logic [MONTH_W-1:0] month_reg;
    logic [DAY_W-1:0]   day_reg;
    logic [DOY_W-1:0]   doy_reg;

    // Result stage.
    gdoy_res_t          res_next;
    gdoy_res_t          res_reg;
    logic               done_reg;

    // The datapath is fully pipelined, so a new transaction fits every cycle.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            in_vld_reg <= accept;
            done_reg   <= in_vld_reg;
        end
    end

    // Payload: hold when idle, load on accept.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg  <= mode;
            year_reg  <= year;
            month_reg <= month;
            day_reg   <= day;
            doy_reg   <= day_of_year;
        end
    end

    // Leap test, month table lookups and the month search all sit here.
    gdoy_conv u_conv (
        .mode        (mode_reg),
        .year        (year_reg),
        .month       (month_reg),
        .day         (day_reg),
        .day_of_year (doy_reg),
        .res         (res_next)
    );

    always_ff @(posedge clk)
    begin
        if (in_vld_reg)
            res_reg <= res_next;
    end

    assign done          = done_reg;
    assign valid_res     = res_reg.valid_res;
    assign leap          = res_reg.leap;
    assign days_in_month = res_reg.days_in_month;
    assign ordinal_day   = res_reg.ordinal_day;
    assign month_out     = res_reg.month_out;
    assign day_out       = res_reg.day_out;

endmodule

/* src/gdoy_conv.sv */
// ----------------------------------------------------------------------------
// gdoy_conv: calendar conversion logic
// Combinational date <-> day-of-year conversion for one registered request.
// ----------------------------------------------------------------------------
module gdoy_conv
    import gdoy_pkg::*;
(
    input  logic               mode,
    input  logic [YEAR_W-1:0]  year,
    input  logic [MONTH_W-1:0] month,
    input  logic [DAY_W-1:0]   day,
    input  logic [DOY_W-1:0]   day_of_year,
    output gdoy_res_t          res
);

    logic               lp;
    logic               year_ok;
    logic               month_ok;
    logic [DAY_W-1:0]   dim_date;
    logic               date_ok;
    logic [DOY_W-1:0]   ord_date;
    logic [DOY_W-1:0]   ylen;
    logic               doy_ok;
    logic [MONTH_W-1:0] mo_found;
    logic [DOY_W-1:0]   rem;

    assign lp      = is_leap(year);
    assign year_ok = (year != '0);

    // date to day of year
    assign month_ok = (month >= MONTH_JAN) && (month <= MONTH_DEC);
    assign dim_date = month_len(month, lp);
    assign date_ok  = year_ok && month_ok && (day != '0) && (day <= dim_date);
    assign ord_date = days_before(month, lp) + {{(DOY_W-DAY_W){1'b0}}, day};

    // day of year to date: thresholds are monotonic, so take the last one passed
    assign ylen   = lp ? LEAP_YEAR_LEN : YEAR_LEN;
    assign doy_ok = year_ok && (day_of_year != '0) && (day_of_year <= ylen);

    always_comb
    begin
        mo_found = MONTH_JAN;
        for (int i = 1; i < NUM_MONTHS; i++)
        begin
            if (day_of_year > days_before(MONTH_W'(i + 1), lp))
                mo_found = MONTH_W'(i + 1);
        end
    end

    assign rem = day_of_year - days_before(mo_found, lp);

    always_comb
    begin
        res      = '0;
        res.leap = lp;
        if (mode == MODE_DATE)
        begin
            res.days_in_month = dim_date;
            if (date_ok)
            begin
                res.valid_res   = 1'b1;
                res.ordinal_day = ord_date;
                res.month_out   = month;
                res.day_out     = day;
            end
        end
        else if (doy_ok)
        begin
            res.valid_res     = 1'b1;
            res.days_in_month = month_len(mo_found, lp);
            res.ordinal_day   = day_of_year;
            res.month_out     = mo_found;
            res.day_out       = rem[DAY_W-1:0];
        end
    end

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb: testbench for the Gregorian date / day-of-year converter
// Drives date and day-of-year requests through the start/busy command port.
// A scoreboard class predicts each result from its own calendar arithmetic
// and checks the results in order as the done strobe marks them.
// ----------------------------------------------------------------------------
module tb;

    import gdoy_pkg::*;

    localparam int LIMIT_CYCLES  = 100000;
    localparam int RANDOM_ITEMS  = 400;
    localparam int DRAIN_CYCLES  = 6;     // pipeline is two stages deep
    localparam int MAX_REPORTS   = 40;

    typedef struct packed {
        logic               mode;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [DOY_W-1:0]   day_of_year;
    } calendar_req_t;

    // ------------------------------------------------------------------------
    // Scoreboard: predict each accepted request, check results in order
    // ------------------------------------------------------------------------
    class calendar_scoreboard;
        gdoy_res_t expected_dates[$];
        int        errors;

        function new();
            errors = 0;
        endfunction

        // Gregorian rule: divisible by 400, or by 4 and not by 100
        function bit gregorian_leap(logic [YEAR_W-1:0] y);
            int yi;
            yi = int'(y);
            return (yi % 400 == 0) || ((yi % 4 == 0) && (yi % 100 != 0));
        endfunction

        function int month_days(int m, bit lp);
            int lengths[NUM_MONTHS];
            lengths = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
            if (m < 1 || m > NUM_MONTHS)
                return 0;
            if (m == int'(MONTH_FEB) && lp)
                return 29;
            return lengths[m - 1];
        endfunction

        function gdoy_res_t convert_calendar(calendar_req_t req);
            gdoy_res_t res;
            bit        lp;
            int        dim;
            int        ord;
            int        m;
            int        rem;
            int        ylen;
            res = '0;
            lp  = gregorian_leap(req.year);
            res.leap = lp;
            if (req.mode == MODE_DATE) begin
                if (req.month >= MONTH_JAN && req.month <= MONTH_DEC) begin
                    dim = month_days(int'(req.month), lp);
                    res.days_in_month = DAY_W'(dim);
                    if (req.year != 0 && req.day != 0 && int'(req.day) <= dim) begin
                        ord = int'(req.day);
                        for (m = 1; m < int'(req.month); m++)
                            ord += month_days(m, lp);
                        res.valid_res   = 1'b1;
                        res.ordinal_day = DOY_W'(ord);
                        res.month_out   = req.month;
                        res.day_out     = req.day;
                    end
                end
            end
            else begin
                ylen = lp ? int'(LEAP_YEAR_LEN) : int'(YEAR_LEN);
                if (req.year != 0 && req.day_of_year != 0 && int'(req.day_of_year) <= ylen)
                begin
                    // walk the month table until the remainder fits
                    m   = 1;
                    rem = int'(req.day_of_year);
                    while (m < NUM_MONTHS) begin
                        if (month_days(m, lp) >= rem)
                            break;
                        rem -= month_days(m, lp);
                        m++;
                    end
                    res.valid_res     = 1'b1;
                    res.days_in_month = DAY_W'(month_days(m, lp));
                    res.ordinal_day   = req.day_of_year;
                    res.month_out     = MONTH_W'(m);
                    res.day_out       = DAY_W'(rem);
                end
            end
            return res;
        endfunction

        function void note_request(calendar_req_t req);
            expected_dates.push_back(convert_calendar(req));
        endfunction

        function void report_field(string name, int exp_val, int act_val);
            if (exp_val != act_val) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: %s mismatch, expected %0d actual %0d",
                             $time, name, exp_val, act_val);
            end
        endfunction

        function void check_result(gdoy_res_t got);
            gdoy_res_t exp;
            if (expected_dates.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none actual %h",
                             $time, got);
                return;
            end
            exp = expected_dates.pop_front();
            report_field("valid_res",     exp.valid_res,     got.valid_res);
            report_field("leap",          exp.leap,          got.leap);
            report_field("days_in_month", exp.days_in_month, got.days_in_month);
            report_field("ordinal_day",   exp.ordinal_day,   got.ordinal_day);
            report_field("month_out",     exp.month_out,     got.month_out);
            report_field("day_out",       exp.day_out,       got.day_out);
        endfunction

        function int pending();
            return expected_dates.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               mode = MODE_DATE;
    logic [YEAR_W-1:0]  year = '0;
    logic [MONTH_W-1:0] month = '0;
    logic [DAY_W-1:0]   day = '0;
    logic [DOY_W-1:0]   day_of_year = '0;
    logic               done;
    logic               valid_res;
    logic               leap;
    logic [DAY_W-1:0]   days_in_month;
    logic [DOY_W-1:0]   ordinal_day;
    logic [MONTH_W-1:0] month_out;
    logic [DAY_W-1:0]   day_out;

    calendar_scoreboard sb = new();
    int                 cycle_count = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    gregorian_date_day_of_year dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .year          (year),
        .month         (month),
        .day           (day),
        .day_of_year   (day_of_year),
        .done          (done),
        .valid_res     (valid_res),
        .leap          (leap),
        .days_in_month (days_in_month),
        .ordinal_day   (ordinal_day),
        .month_out     (month_out),
        .day_out       (day_out)
    );

    // ------------------------------------------------------------------------
    // Monitor: at each rising edge, note an accepted transaction and check
    // a strobed result. Inputs only move on the falling edge, and the DUT
    // updates its outputs after this sample, so no ordering race exists.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            sb.note_request('{mode, year, month, day, day_of_year});
        if (rst_n && done)
            sb.check_result('{valid_res, leap, days_in_month, ordinal_day,
                              month_out, day_out});
    end

    // Watchdog: end a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------------

    // Hold start low for a random gap, then present the request and hold it
    // until the block takes it. Called and returning on a falling edge.
    task automatic send_request(calendar_req_t req, int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge clk);
        end
        start       <= 1'b1;
        mode        <= req.mode;
        year        <= req.year;
        month       <= req.month;
        day         <= req.day;
        day_of_year <= req.day_of_year;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    // Pick a year that stresses the leap rule: century and 400-year marks,
    // multiples of 4, the modern range and the full 16-bit span.
    function automatic logic [YEAR_W-1:0] pick_year();
        int sel;
        sel = $urandom_range(99);
        if (sel < 25)
            return YEAR_W'($urandom_range(65535));
        else if (sel < 45)
            return YEAR_W'($urandom_range(1, 655) * 100);
        else if (sel < 55)
            return YEAR_W'($urandom_range(1, 163) * 400);
        else if (sel < 75)
            return YEAR_W'($urandom_range(1, 16383) * 4);
        else if (sel < 98)
            return YEAR_W'($urandom_range(1583, 2500));
        else
            return YEAR_W'($urandom_range(0, 3));
    endfunction

    // Mostly well-formed requests with random content; the rest is noise.
    function automatic calendar_req_t random_request();
        calendar_req_t req;
        req.mode        = $urandom_range(1) ? MODE_ORDINAL : MODE_DATE;
        req.year        = pick_year();
        req.month       = MONTH_W'($urandom_range(15));
        req.day         = DAY_W'($urandom_range(31));
        req.day_of_year = DOY_W'($urandom_range(511));
        if ($urandom_range(99) < 85) begin
            if (req.mode == MODE_DATE) begin
                req.month = MONTH_W'($urandom_range(1, NUM_MONTHS));
                // days 29..31 probe the month-end boundary
                req.day = ($urandom_range(99) < 70) ? DAY_W'($urandom_range(1, 28))
                                                     : DAY_W'($urandom_range(29, 31));
            end
            else begin
                req.day_of_year = ($urandom_range(99) < 80)
                                  ? DOY_W'($urandom_range(1, 364))
                                  : DOY_W'($urandom_range(365, 367));
            end
        end
        return req;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    calendar_req_t directed_reqs[$];

    initial
    begin
        int i;
        int idle_pct;

        // Date conversions: validity edges, leap rule, ignored day_of_year
        directed_reqs.push_back('{MODE_DATE, 16'd2024, MONTH_JAN, 5'd1,  9'd511});
        directed_reqs.push_back('{MODE_DATE, 16'd2024, MONTH_DEC, 5'd31, 9'd0});
        directed_reqs.push_back('{MODE_DATE, 16'd2023, MONTH_DEC, 5'd31, 9'd300});
        directed_reqs.push_back('{MODE_DATE, 16'd2000, MONTH_FEB, 5'd29, 9'd0});
        directed_reqs.push_back('{MODE_DATE, 16'd1900, MONTH_FEB, 5'd29, 9'd0});
        directed_reqs.push_back('{MODE_DATE, 16'd2023, MONTH_FEB, 5'd28, 9'd0});
        directed_reqs.push_back('{MODE_DATE, 16'd2024, 4'd4,      5'd31, 9'd0});
        directed_reqs.push_back('{MODE_DATE, 16'd2024, 4'd0,      5'd10, 9'd0});
        directed_reqs.push_back('{MODE_DATE, 16'd2024, 4'd13,     5'd10, 9'd0});
        directed_reqs.push_back('{MODE_DATE, 16'd2024, 4'd15,     5'd31, 9'd0});
        directed_reqs.push_back('{MODE_DATE, 16'd2024, 4'd6,      5'd0,  9'd0});
        directed_reqs.push_back('{MODE_DATE, 16'd0,    4'd3,      5'd15, 9'd0});
        directed_reqs.push_back('{MODE_DATE, 16'hFFFF, 4'd11,     5'd30, 9'd0});
        directed_reqs.push_back('{MODE_DATE, 16'd65532, MONTH_FEB, 5'd29, 9'd0});
        // Day-of-year conversions: range edges, leap February, ignored fields
        directed_reqs.push_back('{MODE_ORDINAL, 16'd2023, 4'd15, 5'd31, 9'd1});
        directed_reqs.push_back('{MODE_ORDINAL, 16'd2023, 4'd0,  5'd0,  9'd365});
        directed_reqs.push_back('{MODE_ORDINAL, 16'd2023, 4'd7,  5'd7,  9'd366});
        directed_reqs.push_back('{MODE_ORDINAL, 16'd2024, 4'd7,  5'd7,  9'd366});
        directed_reqs.push_back('{MODE_ORDINAL, 16'd2024, 4'd0,  5'd0,  9'd60});
        directed_reqs.push_back('{MODE_ORDINAL, 16'd2100, 4'd0,  5'd0,  9'd60});
        directed_reqs.push_back('{MODE_ORDINAL, 16'd2024, 4'd0,  5'd0,  9'd0});
        directed_reqs.push_back('{MODE_ORDINAL, 16'd2024, 4'd0,  5'd0,  9'd511});
        directed_reqs.push_back('{MODE_ORDINAL, 16'd0,    4'd0,  5'd0,  9'd100});
        directed_reqs.push_back('{MODE_ORDINAL, 16'hFFFF, 4'd0,  5'd0,  9'd334});
        directed_reqs.push_back('{MODE_ORDINAL, 16'd400,  4'd0,  5'd0,  9'd335});

        // Hold reset, then release it on a falling edge
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_reqs[k])
            send_request(directed_reqs[k], 14);

        // Three phases: light sender gaps, heavy gaps, then back to back
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i < RANDOM_ITEMS / 3)
                idle_pct = 14;
            else if (i < 2 * RANDOM_ITEMS / 3)
                idle_pct = 66;
            else
                idle_pct = 0;
            send_request(random_request(), idle_pct);
        end
        start <= 1'b0;

        // Drain: wait for every expected result, then keep waiting
        // to catch any stray strobe
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
